// File: src/kmsd_pkg.sv
// shared types and constants of the key matrix scanner
package kmsd_pkg;

	localparam int IDX_W  = 3;
	localparam int CNT_W  = 8;
	localparam int LINE_W = 8;
	localparam int REGS_W = 4;
	localparam int CIDX_W = 2;

	localparam logic [LINE_W-1:0] ALL_HIGH = 8'hFF;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_ROW_COUNT      = 2'd0;
	localparam logic [CIDX_W-1:0] REG_COLUMN_COUNT   = 2'd1;
	localparam logic [CIDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd2;

	localparam logic [REGS_W-1:0] ROW_COUNT_RST    = 4'd8;
	localparam logic [REGS_W-1:0] COLUMN_COUNT_RST = 4'd8;
	localparam logic [CNT_W-1:0]  LIMIT_RST        = 8'd5;

	typedef enum logic [3:0] {
		CMD_SET_ROWS    = 4'd0,
		CMD_READ_COLS   = 4'd1,
		CMD_PRESS       = 4'd2,
		CMD_RELEASE     = 4'd3,
		CMD_RELEASE_ALL = 4'd4,
		CMD_QUERY       = 4'd5,
		CMD_SCAN        = 4'd6,
		CMD_TICK        = 4'd7,
		CMD_STABLE      = 4'd8,
		CMD_RESET       = 4'd9
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// state of one key
	typedef struct packed {
		logic             pressed;
		logic [CNT_W-1:0] count;
	} key_t;

endpackage

// File: src/kmsd_cell.sv
// one key cell of the circulating key ring
module kmsd_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift_en,
	input  kmsd_pkg::key_t d,
	output kmsd_pkg::key_t q
);
	import kmsd_pkg::*;

	key_t key_q;

	// take the neighbor's key on every shift cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (shift_en) begin
			key_q <= d;
		end
	end

	assign q = key_q;

endmodule

// File: src/key_matrix_scan_debounce_top.sv
// top level of the key matrix scanner with per-key debounce counters
//
// Usage: one command transaction enters on the input channel (in_valid,
// in_stall) and gives exactly one result transaction on the output channel
// (out_valid, out_stall). The key states sit in a ring of MAX_ROWS *
// MAX_COLUMNS cells that rotates one place per cycle while a command runs;
// the head cell is updated and inspected as each key passes, in row-major
// order, so every command takes one full turn of the ring.
// After the ring turn the command waits in the done state until its result
// is loaded into the output register; in_stall stays high until then, so a
// new command is taken only after the last result has been loaded.
// During the ring turn one key per cycle passes through the head cell.
// The result waits in an output register; while out_stall is high a held
// result holds and a finished command waits before its result is loaded.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are
// always ready and are meant for idle periods; index 3 is ignored.
// Reset clears all keys and counters, drives no row (mask all ones) and
// loads the registers with 8 rows, 8 columns and a limit of 5.
module key_matrix_scan_debounce_top #(
	parameter int MAX_ROWS    = 8,
	parameter int MAX_COLUMNS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [3:0]                  command,
	input  logic [kmsd_pkg::IDX_W-1:0]  key_row,
	input  logic [kmsd_pkg::IDX_W-1:0]  key_column,
	input  logic [kmsd_pkg::LINE_W-1:0] drive_mask,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [kmsd_pkg::LINE_W-1:0] column_lines,
	output logic                        key_found,
	output logic [kmsd_pkg::IDX_W-1:0]  found_row,
	output logic [kmsd_pkg::IDX_W-1:0]  found_column,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [kmsd_pkg::CIDX_W-1:0] cfg_index,
	input  logic [kmsd_pkg::LINE_W-1:0] cfg_data
);
	import kmsd_pkg::*;

	localparam int KEYS = MAX_ROWS * MAX_COLUMNS;
	localparam logic [IDX_W-1:0]  LAST_ROW = IDX_W'(MAX_ROWS - 1);
	localparam logic [IDX_W-1:0]  LAST_COL = IDX_W'(MAX_COLUMNS - 1);
	localparam logic [REGS_W-1:0] ROWS_CAP = REGS_W'(MAX_ROWS);
	localparam logic [REGS_W-1:0] COLS_CAP = REGS_W'(MAX_COLUMNS);

	state_t state_q, state_d;

	logic [REGS_W-1:0] row_count_q, column_count_q;
	logic [CNT_W-1:0]  limit_q;
	logic [LINE_W-1:0] row_drive_q;

	cmd_t              cmd_q;
	logic [IDX_W-1:0]  kr_q, kc_q;
	logic [IDX_W-1:0]  r_q, c_q;

	logic [LINE_W-1:0] lines_q;
	logic              found_q;
	logic [IDX_W-1:0]  frow_q, fcol_q;

	logic              out_valid_q;
	logic [LINE_W-1:0] out_lines_q;
	logic              out_found_q;
	logic [IDX_W-1:0]  out_row_q, out_col_q;

	logic              accept, shift_en, load_out, step_last;
	logic [REGS_W-1:0] nr, nc;
	logic              in_use, at_key, ring_match;
	key_t              head, head_nxt;
	key_t              ring [KEYS];

	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// rows and columns in use, capped by the matrix size
	assign nr = (row_count_q > ROWS_CAP) ? ROWS_CAP : row_count_q;
	assign nc = (column_count_q > COLS_CAP) ? COLS_CAP : column_count_q;

	assign step_last = (r_q == LAST_ROW) && (c_q == LAST_COL);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_RUN;
			ST_RUN:  if (step_last) state_d = ST_DONE;
			ST_DONE: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		shift_en = (state_q == ST_RUN);
		load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= ROW_COUNT_RST;
			column_count_q <= COLUMN_COUNT_RST;
			limit_q        <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROW_COUNT:      row_count_q    <= cfg_data[REGS_W-1:0];
				REG_COLUMN_COUNT:   column_count_q <= cfg_data[REGS_W-1:0];
				REG_DEBOUNCE_LIMIT: limit_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// ring of key cells, head at index 0, updated key re-enters at the tail
	for (genvar i = 0; i < KEYS; i++) begin : g_cell
		key_t d_i;
		if (i == KEYS - 1) begin : g_tail
			assign d_i = head_nxt;
		end else begin : g_mid
			assign d_i = ring[i+1];
		end
		kmsd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.d        (d_i),
			.q        (ring[i])
		);
	end

	assign head   = ring[0];
	assign in_use = ({1'b0, r_q} < nr) && ({1'b0, c_q} < nc);
	assign at_key = in_use && (r_q == kr_q) && (c_q == kc_q);

	// new value of the key passing the head
	always_comb begin
		head_nxt = head;
		unique case (cmd_q)
			CMD_PRESS, CMD_RELEASE: begin
				if (at_key) begin
					head_nxt.pressed = (cmd_q == CMD_PRESS);
					head_nxt.count   = '0;
				end
			end
			CMD_RELEASE_ALL, CMD_RESET: begin
				if (in_use) head_nxt = '0;
			end
			CMD_TICK: begin
				if (in_use) begin
					if (!head.pressed) begin
						head_nxt.count = '0;
					end else if (head.count < limit_q) begin
						head_nxt.count = head.count + CNT_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// first key that matches a scan or stable search
	always_comb begin
		ring_match = 1'b0;
		unique case (cmd_q)
			CMD_SCAN:   ring_match = in_use && head.pressed;
			CMD_STABLE: ring_match = in_use && head.pressed && (head.count >= limit_q);
			default:    ring_match = 1'b0;
		endcase
	end

	// command capture, walk position and pass results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q         <= '0;
			c_q         <= '0;
			row_drive_q <= ALL_HIGH;
			cmd_q       <= CMD_SET_ROWS;
		end else if (accept) begin
			cmd_q <= cmd_t'(command);
			if (cmd_t'(command) == CMD_SET_ROWS) row_drive_q <= drive_mask;
			if (cmd_t'(command) == CMD_RESET)    row_drive_q <= ALL_HIGH;
		end else if (shift_en) begin
			if (c_q == LAST_COL) begin
				c_q <= '0;
				r_q <= step_last ? '0 : r_q + IDX_W'(1);
			end else begin
				c_q <= c_q + IDX_W'(1);
			end
			// scan drives each row in use until a key is found
			if (cmd_q == CMD_SCAN && c_q == '0 && {1'b0, r_q} < nr && !found_q) begin
				row_drive_q <= ~(LINE_W'(1) << r_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kr_q    <= key_row;
			kc_q    <= key_column;
			lines_q <= ALL_HIGH;
			found_q <= 1'b0;
			frow_q  <= '0;
			fcol_q  <= '0;
		end else if (shift_en) begin
			if (cmd_q == CMD_READ_COLS && in_use && !row_drive_q[r_q] && head.pressed) begin
				lines_q[c_q] <= 1'b0;
			end
			if (cmd_q == CMD_QUERY && at_key) begin
				found_q <= head.pressed;
			end
			if (ring_match && !found_q) begin
				found_q <= 1'b1;
				frow_q  <= r_q;
				fcol_q  <= c_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_lines_q <= lines_q;
			out_found_q <= found_q;
			out_row_q   <= frow_q;
			out_col_q   <= fcol_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign column_lines = out_lines_q;
	assign key_found    = out_found_q;
	assign found_row    = out_row_q;
	assign found_column = out_col_q;

	// a result is only loaded at the end of a full ring turn
	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a finished pass");

	// the walk position is home whenever the ring rests
	a_walk_home: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (r_q == '0 && c_q == '0))
		else $error("walk position not at first key while idle");

	// an accepted command always starts a pass
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RUN)
		else $error("accepted command did not start a pass");

endmodule

// File: bench/tb_key_matrix_scan_debounce_top.sv
// testbench of the key matrix scanner: queued command stimulus checked against a matrix model
module tb_key_matrix_scan_debounce_top;
	import kmsd_pkg::*;

	localparam int MAX_ROWS       = 8;
	localparam int MAX_COLUMNS    = 8;
	localparam int KEY_TURN       = MAX_ROWS * MAX_COLUMNS;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 140;

	// commands the block does not know
	localparam logic [3:0] CMD_UNKNOWN_LO = 4'd10;
	localparam logic [3:0] CMD_UNKNOWN_HI = 4'd15;
	// register index with no register behind it
	localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		ACT_COMMAND,
		ACT_CONFIG,
		ACT_DRAIN
	} action_kind_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SPARSE,
		STALL_BURSTS
	} stall_mode_t;

	typedef struct packed {
		action_kind_t      kind;
		logic [3:0]        command;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  column;
		logic [LINE_W-1:0] mask;
		logic [CIDX_W-1:0] reg_index;
		logic [LINE_W-1:0] reg_data;
	} action_t;

	typedef struct packed {
		logic [LINE_W-1:0] column_lines;
		logic              key_found;
		logic [IDX_W-1:0]  found_row;
		logic [IDX_W-1:0]  found_column;
	} readout_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [3:0]        command      = 4'd0;
	logic [IDX_W-1:0]  key_row      = '0;
	logic [IDX_W-1:0]  key_column   = '0;
	logic [LINE_W-1:0] drive_mask   = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [LINE_W-1:0] column_lines;
	logic              key_found;
	logic [IDX_W-1:0]  found_row;
	logic [IDX_W-1:0]  found_column;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index    = '0;
	logic [LINE_W-1:0] cfg_data     = '0;

	key_matrix_scan_debounce_top #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLUMNS(MAX_COLUMNS)
	) dut (.*);

	// matrix model state
	logic [MAX_COLUMNS-1:0] model_pressed [MAX_ROWS] = '{default: '0};
	logic [CNT_W-1:0]       model_settle  [KEY_TURN] = '{default: '0};
	logic [LINE_W-1:0]      model_drive = ALL_HIGH;
	logic [REGS_W-1:0]      model_rows  = ROW_COUNT_RST;
	logic [REGS_W-1:0]      model_cols  = COLUMN_COUNT_RST;
	logic [CNT_W-1:0]       model_limit = LIMIT_RST;

	action_t  queued_actions[$];
	readout_t awaited_readouts[$];

	bit          cmd_taken   = 1'b0;
	bit          cfg_taken   = 1'b0;
	int          fail_count  = 0;
	int          quiet_cycles = 0;
	int          burst_left  = 1;
	int          gap_left    = 0;
	stall_mode_t stall_mode  = STALL_NONE;
	int          stall_span  = 0;
	int          stall_run   = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int rows_in_use();
		return (int'(model_rows) > MAX_ROWS) ? MAX_ROWS : int'(model_rows);
	endfunction

	function automatic int cols_in_use();
		return (int'(model_cols) > MAX_COLUMNS) ? MAX_COLUMNS : int'(model_cols);
	endfunction

	// release every key inside the rows and columns in use
	function automatic void clear_keys_in_use();
		for (int r = 0; r < rows_in_use(); r++) begin
			for (int c = 0; c < cols_in_use(); c++) begin
				model_pressed[r][c] = 1'b0;
				model_settle[r * MAX_COLUMNS + c] = '0;
			end
		end
	endfunction

	// apply one command to the model and return the readout it gives
	function automatic readout_t matrix_step(logic [3:0] cmd, logic [IDX_W-1:0] kr,
			logic [IDX_W-1:0] kc, logic [LINE_W-1:0] mask);
		readout_t res;
		int nr;
		int nc;
		bit hit;
		nr = rows_in_use();
		nc = cols_in_use();
		hit = (int'(kr) < nr) && (int'(kc) < nc);
		res = '0;
		res.column_lines = ALL_HIGH;
		case (cmd)
			CMD_SET_ROWS: model_drive = mask;
			CMD_READ_COLS: begin
				for (int r = 0; r < nr; r++) begin
					if (!model_drive[r]) begin
						for (int c = 0; c < nc; c++)
							if (model_pressed[r][c]) res.column_lines[c] = 1'b0;
					end
				end
			end
			CMD_PRESS, CMD_RELEASE: begin
				if (hit) begin
					model_pressed[kr][kc] = (cmd == CMD_PRESS);
					model_settle[{kr, kc}] = '0;
				end
			end
			CMD_RELEASE_ALL: clear_keys_in_use();
			CMD_QUERY: res.key_found = hit && model_pressed[kr][kc];
			CMD_SCAN: begin
				for (int r = 0; r < nr && !res.key_found; r++) begin
					model_drive = ALL_HIGH;
					model_drive[r] = 1'b0;
					for (int c = 0; c < nc && !res.key_found; c++) begin
						if (model_pressed[r][c]) begin
							res.key_found = 1'b1;
							res.found_row = IDX_W'(r);
							res.found_column = IDX_W'(c);
						end
					end
				end
			end
			CMD_TICK: begin
				for (int r = 0; r < nr; r++) begin
					for (int c = 0; c < nc; c++) begin
						if (!model_pressed[r][c])
							model_settle[r * MAX_COLUMNS + c] = '0;
						else if (model_settle[r * MAX_COLUMNS + c] < model_limit)
							model_settle[r * MAX_COLUMNS + c]++;
					end
				end
			end
			CMD_STABLE: begin
				for (int r = 0; r < nr && !res.key_found; r++) begin
					for (int c = 0; c < nc && !res.key_found; c++) begin
						if (model_pressed[r][c] &&
								model_settle[r * MAX_COLUMNS + c] >= model_limit) begin
							res.key_found = 1'b1;
							res.found_row = IDX_W'(r);
							res.found_column = IDX_W'(c);
						end
					end
				end
			end
			CMD_RESET: begin
				clear_keys_in_use();
				model_drive = ALL_HIGH;
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic check_field(string field, logic [LINE_W-1:0] want, logic [LINE_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	// sample both channels, predict accepted commands and check results
	always @(posedge clk) begin
		readout_t want;
		if (arst_n) begin
			cmd_taken = in_valid && !in_stall;
			cfg_taken = cfg_valid && cfg_ready;
			if (out_valid && !out_stall) begin
				if (awaited_readouts.size() == 0) begin
					$error("result transaction with no command outstanding");
					fail_count++;
				end else begin
					want = awaited_readouts.pop_front();
					check_field("column_lines", want.column_lines, column_lines);
					check_field("key_found", LINE_W'(want.key_found), LINE_W'(key_found));
					check_field("found_row", LINE_W'(want.found_row), LINE_W'(found_row));
					check_field("found_column", LINE_W'(want.found_column),
						LINE_W'(found_column));
				end
			end
			if (cmd_taken)
				awaited_readouts.push_back(matrix_step(command, key_row, key_column, drive_mask));
			if (cfg_taken) begin
				case (cfg_index)
					REG_ROW_COUNT:      model_rows  = cfg_data[REGS_W-1:0];
					REG_COLUMN_COUNT:   model_cols  = cfg_data[REGS_W-1:0];
					REG_DEBOUNCE_LIMIT: model_limit = cfg_data;
					default: ;
				endcase
			end
			// watchdog on cycles with no transaction anywhere
			if (cmd_taken || cfg_taken || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// command and configuration driver, bursts of commands with random gaps
	always @(negedge clk) begin
		logic next_valid;
		logic next_cfg;
		action_t head;
		if (arst_n) begin
			next_valid = in_valid && !cmd_taken;
			next_cfg = cfg_valid && !cfg_taken;
			if (cfg_valid && cfg_taken) queued_actions.pop_front();
			if (!next_valid && !next_cfg && queued_actions.size() > 0) begin
				head = queued_actions[0];
				case (head.kind)
					ACT_COMMAND: begin
						if (gap_left > 0) begin
							gap_left--;
						end else begin
							command    <= head.command;
							key_row    <= head.row;
							key_column <= head.column;
							drive_mask <= head.mask;
							next_valid = 1'b1;
							queued_actions.pop_front();
							if (burst_left > 1) begin
								burst_left--;
							end else begin
								burst_left = $urandom_range(1, 40);
								gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
							end
						end
					end
					ACT_CONFIG: begin
						if (awaited_readouts.size() == 0) begin
							cfg_index <= head.reg_index;
							cfg_data  <= head.reg_data;
							next_cfg = 1'b1;
						end
					end
					default: begin
						if (awaited_readouts.size() == 0) queued_actions.pop_front();
					end
				endcase
			end
			in_valid  <= next_valid;
			cfg_valid <= next_cfg;
		end
	end

	// result receiver, stall pattern switches between modes
	always @(negedge clk) begin
		logic hold;
		if (stall_span > 0) begin
			stall_span--;
		end else begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			stall_span = $urandom_range(50, 400);
		end
		case (stall_mode)
			STALL_NONE:   hold = 1'b0;
			STALL_SPARSE: hold = ($urandom_range(0, 3) == 0);
			default: begin
				if (stall_run > 0) begin
					stall_run--;
					hold = 1'b1;
				end else if ($urandom_range(0, 15) == 0) begin
					stall_run = $urandom_range(1, 80);
					hold = 1'b1;
				end else begin
					hold = 1'b0;
				end
			end
		endcase
		out_stall <= hold;
	end

	function automatic void push_command(logic [3:0] cmd, int row, int col, int mask);
		action_t a;
		a = '0;
		a.kind = ACT_COMMAND;
		a.command = cmd;
		a.row = IDX_W'(row);
		a.column = IDX_W'(col);
		a.mask = LINE_W'(mask);
		queued_actions.push_back(a);
	endfunction

	function automatic void push_config(logic [CIDX_W-1:0] idx, int data);
		action_t a;
		a = '0;
		a.kind = ACT_CONFIG;
		a.reg_index = idx;
		a.reg_data = LINE_W'(data);
		queued_actions.push_back(a);
	endfunction

	function automatic void push_drain();
		action_t a;
		a = '0;
		a.kind = ACT_DRAIN;
		queued_actions.push_back(a);
	endfunction

	// weighted random command, indices mostly inside the matrix in use
	function automatic void push_random_command(int nr, int nc);
		int pick;
		int row;
		int col;
		int mask;
		logic [3:0] cmd;
		pick = $urandom_range(0, 99);
		if (pick < 24) cmd = CMD_PRESS;
		else if (pick < 34) cmd = CMD_RELEASE;
		else if (pick < 54) cmd = CMD_TICK;
		else if (pick < 64) cmd = CMD_STABLE;
		else if (pick < 72) cmd = CMD_SCAN;
		else if (pick < 79) cmd = CMD_QUERY;
		else if (pick < 87) cmd = CMD_READ_COLS;
		else if (pick < 93) cmd = CMD_SET_ROWS;
		else if (pick < 95) cmd = CMD_RELEASE_ALL;
		else if (pick < 96) cmd = CMD_RESET;
		else cmd = 4'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
		if (nr > 0 && $urandom_range(0, 7) != 0) row = $urandom_range(0, nr - 1);
		else row = $urandom_range(0, 7);
		if (nc > 0 && $urandom_range(0, 7) != 0) col = $urandom_range(0, nc - 1);
		else col = $urandom_range(0, 7);
		if ($urandom_range(0, 1) == 0) mask = $urandom_range(0, 255);
		else mask = 255 & ~(1 << $urandom_range(0, 7));
		push_command(cmd, row, col, mask);
	endfunction

	initial begin
		int rows;
		int cols;
		int limit;
		int gen_rows;
		int gen_cols;

		// directed: full matrix, default limit
		push_command(CMD_READ_COLS, 0, 0, 8'h00);
		push_command(CMD_PRESS, 0, 0, 8'h00);
		push_command(CMD_PRESS, 7, 7, 8'hFF);
		push_command(CMD_SET_ROWS, 0, 0, 8'h00);
		push_command(CMD_READ_COLS, 0, 0, 8'h00);
		push_command(CMD_QUERY, 7, 7, 8'h00);
		push_command(CMD_QUERY, 3, 3, 8'h00);
		push_command(CMD_STABLE, 0, 0, 8'h00);
		repeat (LIMIT_RST) push_command(CMD_TICK, 7, 0, 8'hFF);
		push_command(CMD_STABLE, 0, 0, 8'h00);
		push_command(CMD_SCAN, 0, 0, 8'h00);
		push_command(CMD_READ_COLS, 0, 0, 8'h00);
		push_command(CMD_RELEASE, 0, 0, 8'h00);
		push_command(CMD_SCAN, 0, 0, 8'h00);
		push_command(CMD_UNKNOWN_LO, 7, 7, 8'hFF);
		push_command(CMD_UNKNOWN_HI, 0, 7, 8'h00);
		push_command(CMD_RELEASE_ALL, 0, 0, 8'h00);
		push_command(CMD_SCAN, 0, 0, 8'h00);
		push_command(CMD_RESET, 0, 0, 8'h00);

		// small matrix with zero limit, out of range indices
		push_config(REG_ROW_COUNT, 3);
		push_config(REG_COLUMN_COUNT, 2);
		push_config(REG_DEBOUNCE_LIMIT, 0);
		push_config(REG_UNUSED, 8'hA5);
		push_command(CMD_PRESS, 5, 1, 8'h00);
		push_command(CMD_PRESS, 1, 3, 8'h00);
		push_command(CMD_QUERY, 5, 1, 8'h00);
		push_command(CMD_PRESS, 2, 1, 8'h00);
		push_command(CMD_STABLE, 0, 0, 8'h00);
		push_command(CMD_SCAN, 0, 0, 8'h00);

		// no rows in use: scan leaves the drive mask alone
		push_config(REG_ROW_COUNT, 0);
		push_command(CMD_SCAN, 0, 0, 8'h00);
		push_command(CMD_READ_COLS, 0, 0, 8'h00);

		// random phases, each with its own matrix size and limit
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				rows = 8; cols = 8; limit = 255;
			end else if (p == 1) begin
				rows = 15; cols = 9; limit = 0;
			end else if (p == 2) begin
				rows = 0; cols = 8; limit = 3;
			end else if (p == 3) begin
				rows = 1; cols = 1; limit = 1;
			end else begin
				rows = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(4, 8);
				cols = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(4, 8);
				limit = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
			end
			push_config(REG_ROW_COUNT, ($urandom_range(0, 15) << REGS_W) | rows);
			push_config(REG_COLUMN_COUNT, ($urandom_range(0, 15) << REGS_W) | cols);
			push_config(REG_DEBOUNCE_LIMIT, limit);
			gen_rows = (rows > MAX_ROWS) ? MAX_ROWS : rows;
			gen_cols = (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold the sender until the block has drained
				if (i == PHASE_ITEMS / 2 && p % 3 == 0) push_drain();
				push_random_command(gen_rows, gen_cols);
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (queued_actions.size() != 0 || in_valid || cfg_valid ||
				awaited_readouts.size() != 0)
			@(posedge clk);
		repeat (KEY_TURN + 8) @(posedge clk);

		if (fail_count == 0 && awaited_readouts.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
src/kmsd_pkg.sv
src/kmsd_cell.sv
src/key_matrix_scan_debounce_top.sv
bench/tb_key_matrix_scan_debounce_top.sv
